[src/frts_pkg.sv]
// Package for the floppy request track splitter: types, codes and format tables.
// Used by every module of the block; depends on nothing.
`default_nettype none
package frts_pkg;

  localparam int MAX_REQUEST_DEF = 64;
  localparam int RESULT_LIMIT = 8;
  localparam int RESULT_W = $clog2(RESULT_LIMIT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 2'd1;

  localparam logic [2:0] FMT_360K = 3'd0;
  localparam logic [2:0] FMT_400K = 3'd1;
  localparam logic [2:0] FMT_720K = 3'd2;
  localparam logic [2:0] FMT_800K = 3'd3;
  localparam logic [2:0] FMT_1440K = 3'd4;
  localparam logic [2:0] FMT_OTHER = 3'd5;
  localparam logic [2:0] FMT_RSVD6 = 3'd6;
  localparam logic [2:0] FMT_RSVD7 = 3'd7;
  localparam logic [2:0] FMT_RESET = FMT_1440K;

  localparam logic FUNC_READ = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam int SECTOR_W = 12;
  localparam int COUNT_W = 7;
  localparam int OFFSET_W = 6;
  localparam int SPT_W = 5;
  localparam int CYL_W = 6;
  localparam int RECIP_W = 15;
  localparam int DIV_SHIFT = 18;
  localparam int PROD_W = SECTOR_W + RECIP_W;
  localparam int QUOT_W = PROD_W - DIV_SHIFT;
  localparam int QD_W = QUOT_W + CYL_W;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} front_state_t;
  typedef enum logic {B_IDLE, B_RUN} back_state_t;
  typedef enum logic [1:0] {KIND_REFUSE, KIND_SINGLE, KIND_SPLIT} job_kind_t;

  typedef struct packed {
    logic                refused;
    logic                single;
    logic                two_sided;
    logic [SPT_W-1:0]    spt;
    logic [SECTOR_W-1:0] track;
    logic                side;
    logic [SECTOR_W-1:0] sec;
    logic [COUNT_W-1:0]  count;
  } job_t;

  function automatic logic [SPT_W-1:0] spt_of(input logic [2:0] fmt);
    case (fmt)
      FMT_360K:  spt_of = 5'd9;
      FMT_400K:  spt_of = 5'd10;
      FMT_720K:  spt_of = 5'd9;
      FMT_800K:  spt_of = 5'd10;
      FMT_1440K: spt_of = 5'd18;
      default:   spt_of = 5'd18;
    endcase
  endfunction

  function automatic logic two_sided_of(input logic [2:0] fmt);
    case (fmt)
      FMT_360K: two_sided_of = 1'b0;
      FMT_400K: two_sided_of = 1'b0;
      default:  two_sided_of = 1'b1;
    endcase
  endfunction

  function automatic logic [CYL_W-1:0] per_cyl_of(input logic [2:0] fmt);
    case (fmt)
      FMT_360K:  per_cyl_of = 6'd9;
      FMT_400K:  per_cyl_of = 6'd10;
      FMT_720K:  per_cyl_of = 6'd18;
      FMT_800K:  per_cyl_of = 6'd20;
      FMT_1440K: per_cyl_of = 6'd36;
      default:   per_cyl_of = 6'd36;
    endcase
  endfunction

  // Rounded-up reciprocals of the sectors per cylinder, scaled by two to the DIV_SHIFT.
  // They give the exact quotient for every twelve-bit sector number.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] fmt);
    case (fmt)
      FMT_360K:  recip_of = 15'd29128;
      FMT_400K:  recip_of = 15'd26215;
      FMT_720K:  recip_of = 15'd14564;
      FMT_800K:  recip_of = 15'd13108;
      FMT_1440K: recip_of = 15'd7282;
      default:   recip_of = 15'd7282;
    endcase
  endfunction

endpackage
`default_nettype wire

[src/floppy_request_track_splitter.sv]
// A split request passes through the multiply and divide steps of its reciprocal division
// before it is pushed; a refused or unsplit one is pushed directly. The chunk sequencer gives
// one result beat per cycle while a request is split and the output is not stalled, and
// takes the next job only after the last beat of the current one; the front end takes no
// new request until it has pushed the current one. Up to eight results per request.
// Reset (synchronous, active low) empties the job queue and sets format 1440K, unprotected.
`default_nettype none
module floppy_request_track_splitter #(
  parameter int MAX_REQUEST = frts_pkg::MAX_REQUEST_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [frts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [frts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_func,
  input  wire  [frts_pkg::SECTOR_W-1:0]   in_start_sector,
  input  wire  [frts_pkg::COUNT_W-1:0]    in_sector_count,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            out_refused,
  output logic [frts_pkg::SECTOR_W-1:0]   out_track_number,
  output logic                            out_head_side,
  output logic [frts_pkg::SECTOR_W-1:0]   out_sector_in_track,
  output logic [frts_pkg::COUNT_W-1:0]    out_chunk_count,
  output logic [frts_pkg::OFFSET_W-1:0]   out_buffer_offset,
  output logic                            out_last
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  frts_pkg::job_t push_job, pop_job;

  frts_front #(.MAX_REQUEST(MAX_REQUEST)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_start_sector (in_start_sector),
    .in_sector_count (in_sector_count),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_job        (push_job)
  );

  frts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  frts_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_job             (pop_job),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_refused         (out_refused),
    .out_track_number    (out_track_number),
    .out_head_side       (out_head_side),
    .out_sector_in_track (out_sector_in_track),
    .out_chunk_count     (out_chunk_count),
    .out_buffer_offset   (out_buffer_offset),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

[src/frts_front.sv]
// Front end: configuration registers, request intake, classification and
// start position conversion. Depends on frts_pkg.
`default_nettype none
module frts_front #(
  parameter int MAX_REQUEST = frts_pkg::MAX_REQUEST_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [frts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [frts_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_func,
  input  wire  [frts_pkg::SECTOR_W-1:0]     in_start_sector,
  input  wire  [frts_pkg::COUNT_W-1:0]      in_sector_count,
  output logic                              push_valid,
  input  wire                               push_ready,
  output frts_pkg::job_t                    push_job
);

  frts_pkg::front_state_t state_r, state_nxt;
  logic [2:0]                      disk_format_r;
  logic                            write_protect_r;
  frts_pkg::job_kind_t             kind_r, kind_nxt;
  logic [2:0]                      fmt_r;
  logic [frts_pkg::SECTOR_W-1:0]   sector_r;
  logic [frts_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [frts_pkg::PROD_W-1:0]     prod_r;
  logic [frts_pkg::QUOT_W-1:0]     q_r;
  logic [frts_pkg::QD_W-1:0]       qd_r;
  logic [frts_pkg::SECTOR_W-1:0]   rem12;
  logic [frts_pkg::CYL_W-1:0]      rem6, spt6, sec6;
  logic                            side;
  logic                            accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == frts_pkg::F_IDLE);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_format_r   <= frts_pkg::FMT_RESET;
      write_protect_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == frts_pkg::CFG_DISK_FORMAT) begin
        disk_format_r <= cfg_data;
      end else if (cfg_index == frts_pkg::CFG_WRITE_PROTECT) begin
        write_protect_r <= cfg_data[0];
      end
    end
  end

  always_comb begin
    if (32'(in_sector_count) > 32'(MAX_REQUEST)) begin
      count_nxt = frts_pkg::COUNT_W'(MAX_REQUEST);
    end else begin
      count_nxt = in_sector_count;
    end
    if (write_protect_r && (in_func == frts_pkg::FUNC_WRITE)) begin
      kind_nxt = frts_pkg::KIND_REFUSE;
    end else if (disk_format_r > frts_pkg::FMT_1440K) begin
      kind_nxt = frts_pkg::KIND_SINGLE;
    end else begin
      kind_nxt = frts_pkg::KIND_SPLIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frts_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_nxt;
      fmt_r    <= disk_format_r;
      sector_r <= in_start_sector;
      count_r  <= count_nxt;
    end
    if (state_r == frts_pkg::F_MUL) begin
      prod_r <= frts_pkg::PROD_W'(sector_r) * frts_pkg::PROD_W'(frts_pkg::recip_of(fmt_r));
    end
    if (state_r == frts_pkg::F_DIV) begin
      q_r  <= prod_r[frts_pkg::PROD_W-1:frts_pkg::DIV_SHIFT];
      qd_r <= frts_pkg::QD_W'(prod_r[frts_pkg::PROD_W-1:frts_pkg::DIV_SHIFT])
              * frts_pkg::QD_W'(frts_pkg::per_cyl_of(fmt_r));
    end
  end

  always_comb begin
    rem12 = sector_r - qd_r[frts_pkg::SECTOR_W-1:0];
    rem6  = rem12[frts_pkg::CYL_W-1:0];
    spt6  = {1'b0, frts_pkg::spt_of(fmt_r)};
    side  = frts_pkg::two_sided_of(fmt_r) && (rem6 >= spt6);
    sec6  = side ? (rem6 - spt6) : rem6;

    push_job = '0;
    case (kind_r)
      frts_pkg::KIND_REFUSE: begin
        push_job.refused = 1'b1;
        push_job.single  = 1'b1;
      end
      frts_pkg::KIND_SINGLE: begin
        push_job.single = 1'b1;
        push_job.sec    = sector_r;
        push_job.count  = count_r;
      end
      frts_pkg::KIND_SPLIT: begin
        push_job.two_sided = frts_pkg::two_sided_of(fmt_r);
        push_job.spt       = frts_pkg::spt_of(fmt_r);
        push_job.track     = frts_pkg::SECTOR_W'(q_r);
        push_job.side      = side;
        push_job.sec       = frts_pkg::SECTOR_W'(sec6);
        push_job.count     = count_r;
      end
      default: begin
        push_job.refused = 1'b1;
        push_job.single  = 1'b1;
      end
    endcase

    push_valid = (state_r == frts_pkg::F_PUSH);
    state_nxt  = state_r;
    case (state_r)
      frts_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = (kind_nxt == frts_pkg::KIND_SPLIT) ? frts_pkg::F_MUL : frts_pkg::F_PUSH;
        end
      end
      frts_pkg::F_MUL: state_nxt = frts_pkg::F_DIV;
      frts_pkg::F_DIV: state_nxt = frts_pkg::F_PUSH;
      frts_pkg::F_PUSH: begin
        if (push_ready) begin
          state_nxt = frts_pkg::F_IDLE;
        end
      end
      default: state_nxt = frts_pkg::F_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/frts_queue.sv]
// Short job queue between the front end and the chunk sequencer.
// Depends on frts_pkg.
`default_nettype none
module frts_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  wire frts_pkg::job_t  push_job,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output frts_pkg::job_t       pop_job
);

  frts_pkg::job_t                mem [frts_pkg::QUEUE_DEPTH];
  logic [frts_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [frts_pkg::QCNT_W-1:0]   cnt_r;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != frts_pkg::QCNT_W'(frts_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == frts_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == frts_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/frts_back.sv]
// Chunk sequencer: walks one job track by track and drives the result register.
// Depends on frts_pkg.
`default_nettype none
module frts_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             pop_valid,
  output logic                            pop_ready,
  input  wire frts_pkg::job_t             pop_job,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            out_refused,
  output logic [frts_pkg::SECTOR_W-1:0]   out_track_number,
  output logic                            out_head_side,
  output logic [frts_pkg::SECTOR_W-1:0]   out_sector_in_track,
  output logic [frts_pkg::COUNT_W-1:0]    out_chunk_count,
  output logic [frts_pkg::OFFSET_W-1:0]   out_buffer_offset,
  output logic                            out_last
);

  frts_pkg::back_state_t state_r, state_nxt;
  frts_pkg::job_t                  job_r;
  logic [frts_pkg::COUNT_W-1:0]    remain_r;
  logic [frts_pkg::COUNT_W-1:0]    offset_r;
  logic [frts_pkg::RESULT_W-1:0]   n_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [frts_pkg::SPT_W-1:0]      room;
  logic [frts_pkg::COUNT_W-1:0]    room7, piece;
  logic                            done, emit;

  assign out_valid = out_valid_r;
  assign pop_ready = (state_r == frts_pkg::B_IDLE);

  always_comb begin
    room  = job_r.spt - job_r.sec[frts_pkg::SPT_W-1:0];
    room7 = frts_pkg::COUNT_W'(room);
    if (job_r.single || (remain_r <= room7)) begin
      piece = remain_r;
    end else begin
      piece = room7;
    end
    done = job_r.single || (remain_r == piece)
           || (32'(n_r) == frts_pkg::RESULT_LIMIT - 1);
    emit = (state_r == frts_pkg::B_RUN) && (!out_valid_r || out_ready);

    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end

    state_nxt = state_r;
    case (state_r)
      frts_pkg::B_IDLE: begin
        if (pop_valid) begin
          state_nxt = frts_pkg::B_RUN;
        end
      end
      frts_pkg::B_RUN: begin
        if (emit && done) begin
          state_nxt = frts_pkg::B_IDLE;
        end
      end
      default: state_nxt = frts_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frts_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job_r    <= pop_job;
      remain_r <= pop_job.count;
      offset_r <= '0;
      n_r      <= '0;
    end else if (emit && !done) begin
      // A chunk that is not the last always ends on a track boundary.
      remain_r  <= remain_r - piece;
      offset_r  <= offset_r + piece;
      n_r       <= n_r + 1'b1;
      job_r.sec <= '0;
      if (job_r.two_sided && !job_r.side) begin
        job_r.side <= 1'b1;
      end else begin
        job_r.side  <= 1'b0;
        job_r.track <= job_r.track + 1'b1;
      end
    end
    if (emit) begin
      out_refused         <= job_r.refused;
      out_track_number    <= job_r.track;
      out_head_side       <= job_r.side;
      out_sector_in_track <= job_r.sec;
      out_chunk_count     <= piece;
      out_buffer_offset   <= offset_r[frts_pkg::OFFSET_W-1:0];
      out_last            <= done;
    end
  end

endmodule
`default_nettype wire

[src/frts_checker.sv]
// Port-level checks for the floppy request track splitter, bound to its top level.
// Depends on frts_pkg and floppy_request_track_splitter.
`default_nettype none
module frts_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_ready,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire                             out_refused,
  input wire [frts_pkg::SECTOR_W-1:0]    out_track_number,
  input wire                             out_head_side,
  input wire [frts_pkg::SECTOR_W-1:0]    out_sector_in_track,
  input wire [frts_pkg::COUNT_W-1:0]     out_chunk_count,
  input wire [frts_pkg::OFFSET_W-1:0]    out_buffer_offset,
  input wire                             out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_track_number)
      && $stable(out_chunk_count) && $stable(out_buffer_offset) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_refused_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refused |-> out_last && (out_chunk_count == '0)
      && (out_track_number == '0) && !out_head_side && (out_sector_in_track == '0)
      && (out_buffer_offset == '0))
    else $error("refused result carries data");

  a_mid_chunk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_refused && (out_chunk_count != '0))
    else $error("empty or refused chunk before the last one");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front end took two requests back to back");

endmodule

bind floppy_request_track_splitter frts_checker u_frts_checker (.*);
`default_nettype wire
